// ----- design/sfcd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared types, constants and the crc-16/modbus byte update for the framed
// command decoder.
// ----------------------------------------------------------------------------
package sfcd_pkg;

    localparam int unsigned BUFFER_BYTES_DEFAULT = 512;
    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned CRC_BYTES = 2;
    localparam int unsigned PING_PAYLOAD_BYTES = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0]  SYNC_FIRST_RESET = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND_RESET = 8'h55;
    localparam logic [7:0]  VERSION_RESET = 8'h01;
    localparam logic [7:0]  PING_TYPE_RESET = 8'h01;
    localparam logic [15:0] MAX_LEN_RESET = 16'd256;

    localparam int unsigned PADDR_W = 5;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_SYNC_FIRST = 3'd0;
    localparam reg_idx_t REG_SYNC_SECOND = 3'd1;
    localparam reg_idx_t REG_VERSION = 3'd2;
    localparam reg_idx_t REG_PING_TYPE = 3'd3;
    localparam reg_idx_t REG_MAX_LEN = 3'd4;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_PENDING = 2'd0;
    localparam status_t STATUS_REJECT = 2'd1;
    localparam status_t STATUS_PING = 2'd2;

    typedef struct packed {
        status_t     status;
        logic [7:0]  msg_type;
        logic [15:0] sequence_num;
        logic [31:0] nonce_value;
    } result_t;

    // one byte through the reflected crc, eight shift steps unrolled
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- design/sync_frame_crc16_command_decoder.sv -----
`default_nettype none
// a result word is registered into the output register, or into the skid entry while the output is stalled
// throughput: one byte per cycle while in_stall is low; the crc byte update and frame
// tracking are combinational between the frame state registers and the output register
// a two-entry output buffer keeps bytes flowing while one result waits
// reset: asynchronous, clears the frame state and buffers, loads register defaults
// ----------------------------------------------------------------------------
// sync_frame_crc16_command_decoder
// Hunts for a sync pair, gathers header, payload and crc-16/modbus, and
// reports rejected frames and decoded ping commands, one result per byte.
// ----------------------------------------------------------------------------
module sync_frame_crc16_command_decoder #(
    parameter int unsigned BUFFER_BYTES = sfcd_pkg::BUFFER_BYTES_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [7:0]                   rx_byte,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [1:0]                        status,
    output logic [7:0]                        msg_type,
    output logic [15:0]                       sequence_num,
    output logic [31:0]                       nonce_value,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sfcd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int unsigned OFF_W = (CNT_W > 16) ? CNT_W : 16;

    // configuration registers
    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [7:0]  version_cfg_reg;
    logic [7:0]  ping_type_reg;
    logic [15:0] max_len_reg;

    sfcd_pkg::reg_idx_t cfg_idx;
    logic               cfg_write;

    assign pready = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= sfcd_pkg::SYNC_FIRST_RESET;
            sync_second_reg <= sfcd_pkg::SYNC_SECOND_RESET;
            version_cfg_reg <= sfcd_pkg::VERSION_RESET;
            ping_type_reg   <= sfcd_pkg::PING_TYPE_RESET;
            max_len_reg     <= sfcd_pkg::MAX_LEN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                sfcd_pkg::REG_SYNC_FIRST:  sync_first_reg  <= pwdata[7:0];
                sfcd_pkg::REG_SYNC_SECOND: sync_second_reg <= pwdata[7:0];
                sfcd_pkg::REG_VERSION:     version_cfg_reg <= pwdata[7:0];
                sfcd_pkg::REG_PING_TYPE:   ping_type_reg   <= pwdata[7:0];
                sfcd_pkg::REG_MAX_LEN:     max_len_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            sfcd_pkg::REG_SYNC_FIRST:  prdata = {24'h0, sync_first_reg};
            sfcd_pkg::REG_SYNC_SECOND: prdata = {24'h0, sync_second_reg};
            sfcd_pkg::REG_VERSION:     prdata = {24'h0, version_cfg_reg};
            sfcd_pkg::REG_PING_TYPE:   prdata = {24'h0, ping_type_reg};
            sfcd_pkg::REG_MAX_LEN:     prdata = {16'h0, max_len_reg};
            default:                   prdata = 32'h0;
        endcase
    end

    // frame state
    logic [CNT_W-1:0] held_reg,     held_next;
    logic [7:0]       first_reg,    first_next;
    logic [7:0]       version_reg,  version_next;
    logic [7:0]       type_reg,     type_next;
    logic [15:0]      seq_reg,      seq_next;
    logic [15:0]      len_reg,      len_next;
    logic [15:0]      crc_reg,      crc_next;
    logic [31:0]      nonce_reg,    nonce_next;
    logic [7:0]       crc_lo_reg,   crc_lo_next;

    sfcd_pkg::result_t res;
    logic              push;
    logic              pop;

    assign push = in_valid && !in_stall;

    always_comb
    begin
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] off;
        logic [15:0]      len_full;
        logic [15:0]      crc_b;

        held_next    = held_reg;
        first_next   = first_reg;
        version_next = version_reg;
        type_next    = type_reg;
        seq_next     = seq_reg;
        len_next     = len_reg;
        crc_next     = crc_reg;
        nonce_next   = nonce_reg;
        crc_lo_next  = crc_lo_reg;
        res          = '0;
        res.status   = sfcd_pkg::STATUS_PENDING;
        off          = held_reg - CNT_W'(sfcd_pkg::HEADER_BYTES);
        len_full     = {rx_byte, len_reg[7:0]};
        crc_b        = sfcd_pkg::crc_update(crc_reg, rx_byte);

        // buffer full: drop everything and restart the hunt with this byte
        if (held_reg >= CNT_W'(BUFFER_BYTES))
        begin
            pos          = '0;
            version_next = '0;
            type_next    = '0;
            seq_next     = '0;
            len_next     = '0;
            crc_next     = sfcd_pkg::CRC_INIT;
            nonce_next   = '0;
            crc_lo_next  = '0;
        end
        else
        begin
            pos = held_reg;
        end

        if (pos == CNT_W'(0))
        begin
            first_next = rx_byte;
            held_next  = CNT_W'(1);
        end
        else if (pos == CNT_W'(1))
        begin
            if (first_reg == sync_first_reg && rx_byte == sync_second_reg)
                held_next = CNT_W'(2);
            else
                first_next = rx_byte;
        end
        else
        begin
            held_next = pos + CNT_W'(1);
            if (pos < CNT_W'(sfcd_pkg::HEADER_BYTES))
            begin
                crc_next = crc_b;
                if (pos == CNT_W'(2))
                    version_next = rx_byte;
                else if (pos == CNT_W'(3))
                    type_next = rx_byte;
                else if (pos == CNT_W'(4))
                    seq_next = {8'h00, rx_byte};
                else if (pos == CNT_W'(5))
                    seq_next = {rx_byte, seq_reg[7:0]};
                else if (pos == CNT_W'(6))
                    len_next = {8'h00, rx_byte};
                else
                begin
                    len_next = len_full;
                    if (version_reg != version_cfg_reg || len_full > max_len_reg)
                    begin
                        res.status = sfcd_pkg::STATUS_REJECT;
                        held_next  = '0;
                    end
                end
            end
            else if (OFF_W'(off) < OFF_W'(len_reg))
            begin
                crc_next = crc_b;
                if (off < CNT_W'(sfcd_pkg::PING_PAYLOAD_BYTES))
                begin
                    case (off[1:0])
                        2'd0:    nonce_next[7:0]   = rx_byte;
                        2'd1:    nonce_next[15:8]  = rx_byte;
                        2'd2:    nonce_next[23:16] = rx_byte;
                        default: nonce_next[31:24] = rx_byte;
                    endcase
                end
            end
            else if (OFF_W'(off) == OFF_W'(len_reg))
            begin
                crc_lo_next = rx_byte;
            end
            else
            begin
                if ({rx_byte, crc_lo_reg} == crc_reg && type_reg == ping_type_reg
                    && len_reg == 16'(sfcd_pkg::PING_PAYLOAD_BYTES))
                begin
                    res.status       = sfcd_pkg::STATUS_PING;
                    res.msg_type     = type_reg;
                    res.sequence_num = seq_reg;
                    res.nonce_value  = nonce_reg;
                end
                else
                begin
                    res.status = sfcd_pkg::STATUS_REJECT;
                end
                held_next = '0;
            end

            // any frame end or rejection clears the held bytes
            if (held_next == '0)
            begin
                first_next   = '0;
                version_next = '0;
                type_next    = '0;
                seq_next     = '0;
                len_next     = '0;
                crc_next     = sfcd_pkg::CRC_INIT;
                nonce_next   = '0;
                crc_lo_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            first_reg   <= '0;
            version_reg <= '0;
            type_reg    <= '0;
            seq_reg     <= '0;
            len_reg     <= '0;
            crc_reg     <= sfcd_pkg::CRC_INIT;
            nonce_reg   <= '0;
            crc_lo_reg  <= '0;
        end
        else if (push)
        begin
            held_reg    <= held_next;
            first_reg   <= first_next;
            version_reg <= version_next;
            type_reg    <= type_next;
            seq_reg     <= seq_next;
            len_reg     <= len_next;
            crc_reg     <= crc_next;
            nonce_reg   <= nonce_next;
            crc_lo_reg  <= crc_lo_next;
        end
    end

    // output register with a skid entry behind it
    logic              main_valid_reg;
    logic              skid_valid_reg;
    sfcd_pkg::result_t main_reg;
    sfcd_pkg::result_t skid_reg;

    assign pop       = main_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;
    assign out_valid = main_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!main_valid_reg || pop)
            begin
                if (skid_valid_reg)
                begin
                    main_valid_reg <= 1'b1;
                    skid_valid_reg <= push;
                end
                else
                begin
                    main_valid_reg <= push;
                end
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
                if (push)
                    skid_reg <= res;
            end
            else if (push)
            begin
                main_reg <= res;
            end
        end
        else if (push)
        begin
            skid_reg <= res;
        end
    end

    assign status       = main_reg.status;
    assign msg_type     = main_reg.msg_type;
    assign sequence_num = main_reg.sequence_num;
    assign nonce_value  = main_reg.nonce_value;

endmodule
`default_nettype wire

// ----- design/sfcd_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfcd_checker
// Port-level checks for the framed command decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sfcd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  status,
    input wire logic [7:0]  msg_type,
    input wire logic [15:0] sequence_num,
    input wire logic [31:0] nonce_value
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(msg_type)
            && $stable(sequence_num) && $stable(nonce_value))
        else $error("stalled result changed");

    // every accepted byte leaves a result word visible next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted byte left no result");

    // input backpressure only follows a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("input stalled without output stall");

    // fields are zero unless a ping was decoded
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != sfcd_pkg::STATUS_PING |->
            msg_type == 8'h00 && sequence_num == 16'h0000 && nonce_value == 32'h0)
        else $error("nonzero fields on non-ping result");

endmodule

bind sync_frame_crc16_command_decoder sfcd_checker u_sfcd_checker (.*);
`default_nettype wire

// ----- verif/tb_sync_frame_crc16_command_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_sync_frame_crc16_command_decoder
// Streams noise and framed traffic into the decoder under several register
// settings and idle patterns. A built-in frame tracker predicts one result word
// per byte, and each result is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_sync_frame_crc16_command_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAME_BUF = sfcd_pkg::BUFFER_BYTES_DEFAULT;
    localparam int unsigned HDR_LEN = 8;
    localparam int unsigned NONCE_LEN = 4;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_BYTES = 180;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [7:0]  msg_type;
    logic [15:0] sequence_num;
    logic [31:0] nonce_value;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [sfcd_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sync_frame_crc16_command_decoder #(
        .BUFFER_BYTES(FRAME_BUF)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .msg_type(msg_type),
        .sequence_num(sequence_num),
        .nonce_value(nonce_value),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // register copies
    logic [7:0]  cfg_sync_a = sfcd_pkg::SYNC_FIRST_RESET;
    logic [7:0]  cfg_sync_b = sfcd_pkg::SYNC_SECOND_RESET;
    logic [7:0]  cfg_version = sfcd_pkg::VERSION_RESET;
    logic [7:0]  cfg_ping_type = sfcd_pkg::PING_TYPE_RESET;
    logic [15:0] cfg_max_len = sfcd_pkg::MAX_LEN_RESET;

    // frame tracker state
    int unsigned held_count = 0;
    logic [7:0]  hunt_byte = '0;
    logic [7:0]  hdr_version = '0;
    logic [7:0]  hdr_type = '0;
    logic [15:0] hdr_seq = '0;
    logic [15:0] hdr_len = '0;
    logic [15:0] crc_run = sfcd_pkg::CRC_INIT;
    logic [31:0] nonce_run = '0;
    logic [7:0]  crc_lo = '0;

    logic [7:0]        byte_queue[$];
    sfcd_pkg::result_t pending_results[$];
    int         bytes_planned = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       in_fire = 1'b0;
    int         idle_cycles = 0;
    int         error_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc,
                                                    input logic [7:0] data);
        logic [15:0] r;
        r = acc ^ {8'h00, data};
        repeat (8)
            r = r[0] ? ((r >> 1) ^ sfcd_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic void drop_frame();
        held_count = 0;
        hunt_byte = '0;
        hdr_version = '0;
        hdr_type = '0;
        hdr_seq = '0;
        hdr_len = '0;
        crc_run = sfcd_pkg::CRC_INIT;
        nonce_run = '0;
        crc_lo = '0;
    endfunction

    function automatic sfcd_pkg::result_t decode_step(input logic [7:0] b);
        sfcd_pkg::result_t r;
        int unsigned       pos;
        int unsigned       off;
        r = '0;
        r.status = sfcd_pkg::STATUS_PENDING;
        // full buffer: drop everything silently, this byte restarts the hunt
        if (held_count >= FRAME_BUF)
            drop_frame();
        pos = held_count;
        if (pos == 0)
        begin
            hunt_byte = b;
            held_count = 1;
        end
        else if (pos == 1)
        begin
            if (hunt_byte == cfg_sync_a && b == cfg_sync_b)
                held_count = 2;
            else
                hunt_byte = b;
        end
        else
        begin
            held_count = pos + 1;
            if (pos < HDR_LEN)
            begin
                crc_run = modbus_crc_step(crc_run, b);
                case (pos)
                    2: hdr_version = b;
                    3: hdr_type = b;
                    4: hdr_seq = {8'h00, b};
                    5: hdr_seq[15:8] = b;
                    6: hdr_len = {8'h00, b};
                    default:
                    begin
                        hdr_len[15:8] = b;
                        if (hdr_version != cfg_version || hdr_len > cfg_max_len)
                        begin
                            drop_frame();
                            r.status = sfcd_pkg::STATUS_REJECT;
                        end
                    end
                endcase
            end
            else
            begin
                off = pos - HDR_LEN;
                if (off < hdr_len)
                begin
                    crc_run = modbus_crc_step(crc_run, b);
                    if (off < NONCE_LEN)
                        nonce_run[8*off +: 8] = b;
                end
                else if (off == hdr_len)
                    crc_lo = b;
                else
                begin
                    if ({b, crc_lo} == crc_run && hdr_type == cfg_ping_type
                        && hdr_len == NONCE_LEN)
                    begin
                        r.status = sfcd_pkg::STATUS_PING;
                        r.msg_type = hdr_type;
                        r.sequence_num = hdr_seq;
                        r.nonce_value = nonce_run;
                    end
                    else
                        r.status = sfcd_pkg::STATUS_REJECT;
                    drop_frame();
                end
            end
        end
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // driver: next word only once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                rx_byte <= byte_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result word mismatch, expected none, actual status %0h",
                             $time, status);
                    error_count++;
                end
                else
                begin
                    sfcd_pkg::result_t want;
                    want = pending_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(status));
                    compare_field("msg_type", 32'(want.msg_type), 32'(msg_type));
                    compare_field("sequence_num", 32'(want.sequence_num), 32'(sequence_num));
                    compare_field("nonce_value", want.nonce_value, nonce_value);
                end
            end
            if (in_valid && !in_stall)
                pending_results.push_back(decode_step(rx_byte));
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, %0d words still expected", $time,
                         pending_results.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic apb_write(input sfcd_pkg::reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            sfcd_pkg::REG_SYNC_FIRST: cfg_sync_a = value[7:0];
            sfcd_pkg::REG_SYNC_SECOND: cfg_sync_b = value[7:0];
            sfcd_pkg::REG_VERSION: cfg_version = value[7:0];
            sfcd_pkg::REG_PING_TYPE: cfg_ping_type = value[7:0];
            sfcd_pkg::REG_MAX_LEN: cfg_max_len = value[15:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [7:0] sync_a, input logic [7:0] sync_b,
                               input logic [7:0] ver, input logic [7:0] ping,
                               input logic [15:0] max_len);
        apb_write(sfcd_pkg::REG_SYNC_FIRST, 32'(sync_a));
        apb_write(sfcd_pkg::REG_SYNC_SECOND, 32'(sync_b));
        apb_write(sfcd_pkg::REG_VERSION, 32'(ver));
        apb_write(sfcd_pkg::REG_PING_TYPE, 32'(ping));
        apb_write(sfcd_pkg::REG_MAX_LEN, 32'(max_len));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (byte_queue.size() != 0 || in_valid || pending_results.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        byte_queue.push_back(b);
        bytes_planned++;
    endtask

    // keep limits how many bytes of the frame go out
    task automatic push_frame(input logic [7:0] ver, input logic [7:0] kind,
                              input logic [15:0] seq, input logic [15:0] plen,
                              input logic [15:0] crc_err, input int keep);
        logic [7:0]  fr[$];
        logic [15:0] crc;
        int          i;
        fr = {cfg_sync_a, cfg_sync_b, ver, kind, seq[7:0], seq[15:8], plen[7:0], plen[15:8]};
        for (i = 0; i < int'(plen) && fr.size() < keep; i++)
            fr.push_back(8'($urandom));
        if (fr.size() == HDR_LEN + plen)
        begin
            crc = sfcd_pkg::CRC_INIT;
            for (i = 2; i < fr.size(); i++)
                crc = modbus_crc_step(crc, fr[i]);
            crc ^= crc_err;
            fr.push_back(crc[7:0]);
            fr.push_back(crc[15:8]);
        end
        for (i = 0; i < fr.size() && i < keep; i++)
            push_byte(fr[i]);
    endtask

    task automatic push_random_frame();
        logic [7:0]  ver;
        logic [7:0]  kind;
        logic [15:0] plen;
        logic [15:0] crc_err;
        int          pick;
        int          keep;
        if ($urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
        ver = ($urandom_range(0, 99) < 8) ? 8'($urandom) : cfg_version;
        kind = ($urandom_range(0, 99) < 15) ? 8'($urandom) : cfg_ping_type;
        pick = $urandom_range(0, 99);
        if (pick < 76)
            plen = 16'(NONCE_LEN);
        else if (pick < 90)
            plen = 16'($urandom_range(0, 8));
        else
            plen = cfg_max_len + 16'd1;
        crc_err = ($urandom_range(0, 99) < 8) ? (16'd1 << $urandom_range(0, 15)) : 16'd0;
        keep = ($urandom_range(0, 99) < 5) ? $urandom_range(1, 12) : FRAME_BUF;
        push_frame(ver, kind, 16'($urandom), plen, crc_err, keep);
    endtask

    task automatic push_traffic(input int budget);
        int start;
        start = bytes_planned;
        while (bytes_planned - start < budget)
            push_random_frame();
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 78;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 78;
            end
            default:
            begin
                send_idle_pct = 14;
                recv_stall_pct = 14;
            end
        endcase
    endtask

    initial
    begin
        int phase;
        drop_frame();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed, reset register values: hunting over near-miss bytes,
        // a good ping, then a header with the wrong version
        set_idling(0);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hAA);
        push_frame(8'h01, 8'h01, 16'h1234, 16'(NONCE_LEN), 16'h0000, FRAME_BUF);
        push_frame(8'h02, 8'h01, 16'h0000, 16'(NONCE_LEN), 16'h0000, HDR_LEN);
        wait_drained();

        for (phase = 1; phase <= 7; phase++)
        begin
            case (phase)
                1: load_config(8'h00, 8'hFF, 8'h00, 8'hFF, 16'h0000);
                2: load_config(8'hFF, 8'h00, 8'hFF, 8'h00, 16'hFFFF);
                3: load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               16'($urandom_range(4, 64)));
                4: load_config(8'h7E, 8'h7E, 8'($urandom), 8'($urandom), 16'd600);
                5: load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               16'(NONCE_LEN));
                6: load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               16'($urandom_range(0, 300)));
                default: load_config(sfcd_pkg::SYNC_FIRST_RESET, sfcd_pkg::SYNC_SECOND_RESET,
                                     sfcd_pkg::VERSION_RESET, sfcd_pkg::PING_TYPE_RESET,
                                     sfcd_pkg::MAX_LEN_RESET);
            endcase
            set_idling(phase % 4);
            if (phase == 4)
            begin
                // long frame that fills the buffer, the next byte flushes it
                push_frame(cfg_version, cfg_ping_type, 16'($urandom), 16'd600, 16'h0000,
                           FRAME_BUF);
                push_traffic(PHASE_BYTES / 2);
            end
            else if (phase == 3)
            begin
                push_traffic(PHASE_BYTES / 2);
                // hold the sender until every result is back
                wait_drained();
                push_traffic(PHASE_BYTES / 2);
            end
            else
                push_traffic(PHASE_BYTES);
            wait_drained();
        end

        repeat (8) @(negedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
